@@ src/upscale2x_box3x3_rgb_core_macros.svh @@
// Assertion macros for the upscaler RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef UPSCALE2X_BOX3X3_RGB_CORE_MACROS_SVH
`define UPSCALE2X_BOX3X3_RGB_CORE_MACROS_SVH

// Implication checked in the same cycle.
`define UBX_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the following cycle.
`define UBX_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/ubx_pkg.sv @@
// Shared types, widths and codes of the 2x upscaler with 3x3 box filter.
// No dependencies; all files of the block but the macro header refer to it.
`timescale 1ns / 1ps

package ubx_pkg;

	localparam int DEF_MAX_SRC_WIDTH  = 256;
	localparam int DEF_MAX_SRC_HEIGHT = 256;

	localparam int POS_W      = 9;
	localparam int DIM_W      = 9;
	localparam int CH_W       = 8;
	localparam int NUM_CH     = 3;
	localparam int PIX_W      = NUM_CH * CH_W;
	localparam int ACC_W      = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 1'd1;

	localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	// Division by nine as a multiply by ceil(2^15 / 9) and a shift; exact for sums
	// below 9 * 256.
	localparam int RECIP_W     = 12;
	localparam int RECIP_SHIFT = 15;
	localparam logic [RECIP_W-1:0] BOX_RECIP = 12'd3641;

	localparam logic [ACC_W-1:0] BOX_SUM_MAX = 12'd2295;
	localparam logic [ACC_W-1:0] CH_MAX      = 12'd255;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_BORDER,
		CMD_BOX,
		CMD_RANGE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [POS_W-1:0]       r0;
		logic [POS_W-1:0]       r1;
		logic [POS_W-1:0]       c0;
		logic [POS_W-1:0]       c1;
		logic                   r0_dbl;
		logic                   c0_dbl;
		logic [PIX_W-1:0]       pix;
	} cmd_t;

	typedef struct packed {
		logic [DIM_W-1:0] sw;
		logic [DIM_W-1:0] sh;
	} dims_t;

	typedef struct packed {
		logic vld;
		cmd_t cmd;
	} q_push_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_LAST,
		ST_DONE
	} back_state_t;

endpackage

@@ src/ubx_if.sv @@
// Request and response channels of the upscaler, valid/ready handshake.
// Depends on ubx_pkg for field widths.
`timescale 1ns / 1ps

interface ubx_req_if;
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic [ubx_pkg::POS_W-1:0]    row_pos;
	logic [ubx_pkg::POS_W-1:0]    col_pos;
	logic [ubx_pkg::CH_W-1:0]     in_red;
	logic [ubx_pkg::CH_W-1:0]     in_green;
	logic [ubx_pkg::CH_W-1:0]     in_blue;

	modport source (output valid, action, row_pos, col_pos, in_red, in_green, in_blue,
		input ready);
	modport sink (input valid, action, row_pos, col_pos, in_red, in_green, in_blue,
		output ready);
endinterface

interface ubx_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ubx_pkg::CH_W-1:0]     out_red;
	logic [ubx_pkg::CH_W-1:0]     out_green;
	logic [ubx_pkg::CH_W-1:0]     out_blue;
	logic                         status;

	modport source (output valid, out_red, out_green, out_blue, status, input ready);
	modport sink (input valid, out_red, out_green, out_blue, status, output ready);
endinterface

@@ src/upscale2x_box3x3_rgb_core.sv @@
// Top level of the 2x RGB upscaler with 3x3 box filter.
// Depends on ubx_pkg, ubx_if.sv, ubx_front, ubx_queue and ubx_back.
`timescale 1ns / 1ps

// A load beat inside the source frame writes one pixel into the frame store; a
// read beat names a pixel of the doubled image and returns one response beat.
// Border pixels copy the nearest source pixel, interior pixels are the
// truncated mean of the 3x3 window mapped back to source pixels, and a
// position outside the doubled frame answers with status 1 and zero channels.
// The frame store has a single port, and its sequencer handles one command at
// a time: a border read fetches one source pixel and an interior read its four
// distinct source pixels, one per cycle. A two-entry command queue lets the
// request side keep accepting while the sequencer works, and the response
// register lets a finished result wait without holding it up.
// The store needs no clearing after reset; only written pixels may be read.
// source_width and source_height may be written only while the block is idle.
module upscale2x_box3x3_rgb_core #(
	parameter int MAX_SRC_WIDTH  = ubx_pkg::DEF_MAX_SRC_WIDTH,
	parameter int MAX_SRC_HEIGHT = ubx_pkg::DEF_MAX_SRC_HEIGHT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [ubx_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ubx_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
	ubx_req_if.sink                          req,
	ubx_rsp_if.source                        rsp
);

	logic [ubx_pkg::DIM_W-1:0] src_w_q;
	logic [ubx_pkg::DIM_W-1:0] src_h_q;
	ubx_pkg::dims_t            dims;
	ubx_pkg::q_push_t          push;
	logic                      full;
	logic                      pop;
	logic                      nonempty;
	ubx_pkg::cmd_t             head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= ubx_pkg::DIM_RESET;
			src_h_q <= ubx_pkg::DIM_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ubx_pkg::CFG_SOURCE_WIDTH:  src_w_q <= cfg_wr_data;
				ubx_pkg::CFG_SOURCE_HEIGHT: src_h_q <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	// Effective size is the register clamped to 1..maximum.
	always_comb begin
		if (src_w_q == '0) dims.sw = ubx_pkg::DIM_W'(1);
		else if (32'(src_w_q) > 32'(MAX_SRC_WIDTH)) dims.sw = ubx_pkg::DIM_W'(MAX_SRC_WIDTH);
		else dims.sw = src_w_q;
		if (src_h_q == '0) dims.sh = ubx_pkg::DIM_W'(1);
		else if (32'(src_h_q) > 32'(MAX_SRC_HEIGHT)) dims.sh = ubx_pkg::DIM_W'(MAX_SRC_HEIGHT);
		else dims.sh = src_h_q;
	end

	ubx_front u_front (
		.req  (req),
		.dims (dims),
		.full (full),
		.push (push)
	);

	ubx_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.pop      (pop),
		.nonempty (nonempty),
		.head     (head)
	);

	ubx_back #(
		.MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
		.MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nonempty (nonempty),
		.head     (head),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule

@@ src/ubx_front.sv @@
// Front end: turns request beats into store commands; drops off-frame loads.
// Depends on ubx_pkg and the request interface in ubx_if.sv.
`timescale 1ns / 1ps

module ubx_front (
	ubx_req_if.sink          req,
	input  ubx_pkg::dims_t   dims,
	input  logic             full,
	output ubx_pkg::q_push_t push
);

	logic [ubx_pkg::POS_W:0]   ow;
	logic [ubx_pkg::POS_W:0]   oh;
	logic [ubx_pkg::POS_W:0]   row_x;
	logic [ubx_pkg::POS_W:0]   col_x;
	logic [ubx_pkg::POS_W-1:0] rm1;
	logic [ubx_pkg::POS_W-1:0] rp1;
	logic [ubx_pkg::POS_W-1:0] cm1;
	logic [ubx_pkg::POS_W-1:0] cp1;
	logic                      drop;
	ubx_pkg::cmd_t             cmd;

	assign req.ready = !full;

	always_comb begin
		ow    = {dims.sw, 1'b0};
		oh    = {dims.sh, 1'b0};
		row_x = {1'b0, req.row_pos};
		col_x = {1'b0, req.col_pos};
		rm1   = req.row_pos - ubx_pkg::POS_W'(1);
		rp1   = req.row_pos + ubx_pkg::POS_W'(1);
		cm1   = req.col_pos - ubx_pkg::POS_W'(1);
		cp1   = req.col_pos + ubx_pkg::POS_W'(1);
		drop  = 1'b0;

		cmd.kind   = ubx_pkg::CMD_LOAD;
		cmd.r0     = req.row_pos;
		cmd.r1     = req.row_pos;
		cmd.c0     = req.col_pos;
		cmd.c1     = req.col_pos;
		cmd.r0_dbl = 1'b0;
		cmd.c0_dbl = 1'b0;
		cmd.pix    = {req.in_red, req.in_green, req.in_blue};

		if (req.action == ubx_pkg::ACT_LOAD) begin
			drop = !(req.row_pos < dims.sh && req.col_pos < dims.sw);
		end else if (row_x >= oh || col_x >= ow) begin
			cmd.kind = ubx_pkg::CMD_RANGE;
		end else if (req.row_pos == '0 || req.col_pos == '0 ||
				row_x == oh - 1'b1 || col_x == ow - 1'b1) begin
			cmd.kind = ubx_pkg::CMD_BORDER;
			cmd.r0   = {1'b0, req.row_pos[ubx_pkg::POS_W-1:1]};
			cmd.c0   = {1'b0, req.col_pos[ubx_pkg::POS_W-1:1]};
		end else begin
			// The 3x3 window covers two source rows and two source columns. The
			// nearer one counts twice: the lower index for odd positions.
			cmd.kind   = ubx_pkg::CMD_BOX;
			cmd.r0     = {1'b0, rm1[ubx_pkg::POS_W-1:1]};
			cmd.r1     = {1'b0, rp1[ubx_pkg::POS_W-1:1]};
			cmd.c0     = {1'b0, cm1[ubx_pkg::POS_W-1:1]};
			cmd.c1     = {1'b0, cp1[ubx_pkg::POS_W-1:1]};
			cmd.r0_dbl = req.row_pos[0];
			cmd.c0_dbl = req.col_pos[0];
		end

		push.vld = req.valid && !full && !drop;
		push.cmd = cmd;
	end

endmodule

@@ src/ubx_queue.sv @@
// Short command queue between the front end and the frame-store sequencer.
// Depends on ubx_pkg for the command type and depth.
`timescale 1ns / 1ps

module ubx_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  ubx_pkg::q_push_t push,
	output logic             full,
	input  logic             pop,
	output logic             nonempty,
	output ubx_pkg::cmd_t    head
);

	localparam int PTR_W = (ubx_pkg::QUEUE_DEPTH > 1) ? $clog2(ubx_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(ubx_pkg::QUEUE_DEPTH + 1);

	ubx_pkg::cmd_t       entry_q [ubx_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                do_push;
	logic                do_pop;

	assign full     = cnt_q == CNT_W'(ubx_pkg::QUEUE_DEPTH);
	assign nonempty = cnt_q != '0;
	assign head     = entry_q[rd_ptr_q];
	assign do_push  = push.vld && !full;
	assign do_pop   = pop && nonempty;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(ubx_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push.cmd;
	end

endmodule

@@ src/ubx_back.sv @@
// Back end: frame store, access sequencer, weighted accumulation, divide by nine
// and the response register. Depends on ubx_pkg, ubx_if.sv and the macro header.
`timescale 1ns / 1ps
`include "upscale2x_box3x3_rgb_core_macros.svh"

module ubx_back #(
	parameter int MAX_SRC_WIDTH  = ubx_pkg::DEF_MAX_SRC_WIDTH,
	parameter int MAX_SRC_HEIGHT = ubx_pkg::DEF_MAX_SRC_HEIGHT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          nonempty,
	input  ubx_pkg::cmd_t head,
	output logic          pop,
	ubx_rsp_if.source     rsp
);

	localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int PROD_W      = ubx_pkg::ACC_W + ubx_pkg::RECIP_W;

	logic [ubx_pkg::PIX_W-1:0]  mem [STORE_DEPTH];
	logic [ubx_pkg::PIX_W-1:0]  rd_data_q;

	ubx_pkg::back_state_t       state_q;
	ubx_pkg::back_state_t       state_d;
	logic [1:0]                 step_q;
	logic [1:0]                 step_d;
	ubx_pkg::cmd_t              cmd_q;
	logic [ubx_pkg::ACC_W-1:0]  acc_q [ubx_pkg::NUM_CH];
	logic                       rd_vld_q;
	logic [1:0]                 rd_sh_q;
	logic                       out_vld_q;
	logic [ubx_pkg::CH_W-1:0]   out_ch_q [ubx_pkg::NUM_CH];
	logic                       status_q;

	logic                       mem_we;
	logic                       mem_re;
	logic                       out_load;
	logic [ubx_pkg::POS_W-1:0]  row_sel;
	logic [ubx_pkg::POS_W-1:0]  col_sel;
	logic                       dbl_r;
	logic                       dbl_c;
	logic [1:0]                 sh_amt;
	logic [ADDR_W-1:0]          addr;

	function automatic logic [ubx_pkg::CH_W-1:0] div9(input logic [ubx_pkg::ACC_W-1:0] s);
		logic [PROD_W-1:0] p;
		p = PROD_W'(s) * PROD_W'(ubx_pkg::BOX_RECIP);
		return p[ubx_pkg::RECIP_SHIFT +: ubx_pkg::CH_W];
	endfunction

	// Step order: (r0,c0), (r0,c1), (r1,c0), (r1,c1). Each pixel is weighted by
	// a shift of 0, 1 or 2 for the 1-2-1 footprint of the window.
	always_comb begin
		row_sel = step_q[1] ? cmd_q.r1 : cmd_q.r0;
		col_sel = step_q[0] ? cmd_q.c1 : cmd_q.c0;
		dbl_r   = step_q[1] ? !cmd_q.r0_dbl : cmd_q.r0_dbl;
		dbl_c   = step_q[0] ? !cmd_q.c0_dbl : cmd_q.c0_dbl;
		sh_amt  = {1'b0, dbl_r} + {1'b0, dbl_c};
		addr    = ADDR_W'(32'(row_sel) * 32'(MAX_SRC_WIDTH) + 32'(col_sel));
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		pop      = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ubx_pkg::ST_IDLE: begin
				if (nonempty) begin
					pop     = 1'b1;
					step_d  = '0;
					state_d = ubx_pkg::ST_ISSUE;
				end
			end
			ubx_pkg::ST_ISSUE: begin
				case (cmd_q.kind)
					ubx_pkg::CMD_LOAD: begin
						mem_we  = 1'b1;
						state_d = ubx_pkg::ST_IDLE;
					end
					ubx_pkg::CMD_RANGE: begin
						state_d = ubx_pkg::ST_DONE;
					end
					ubx_pkg::CMD_BORDER: begin
						mem_re  = 1'b1;
						state_d = ubx_pkg::ST_LAST;
					end
					ubx_pkg::CMD_BOX: begin
						mem_re = 1'b1;
						if (step_q == 2'd3) state_d = ubx_pkg::ST_LAST;
						else step_d = step_q + 1'b1;
					end
					default: state_d = ubx_pkg::ST_IDLE;
				endcase
			end
			ubx_pkg::ST_LAST: begin
				state_d = ubx_pkg::ST_DONE;
			end
			ubx_pkg::ST_DONE: begin
				if (!out_vld_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ubx_pkg::ST_IDLE;
				end
			end
			default: state_d = ubx_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ubx_pkg::ST_IDLE;
			step_q    <= '0;
			rd_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			step_q   <= step_d;
			rd_vld_q <= mem_re;
			if (out_load) out_vld_q <= 1'b1;
			else if (rsp.ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[addr] <= cmd_q.pix;
		if (mem_re) rd_data_q <= mem[addr];
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= head;
		rd_sh_q <= sh_amt;
		for (int i = 0; i < ubx_pkg::NUM_CH; i++) begin
			if (pop) begin
				acc_q[i] <= '0;
			end else if (rd_vld_q) begin
				acc_q[i] <= acc_q[i] + (ubx_pkg::ACC_W'(
					rd_data_q[(ubx_pkg::NUM_CH - 1 - i) * ubx_pkg::CH_W +: ubx_pkg::CH_W])
					<< rd_sh_q);
			end
		end
		if (out_load) begin
			status_q <= (cmd_q.kind == ubx_pkg::CMD_RANGE) ? ubx_pkg::STATUS_RANGE
				: ubx_pkg::STATUS_OK;
			for (int i = 0; i < ubx_pkg::NUM_CH; i++) begin
				case (cmd_q.kind)
					ubx_pkg::CMD_BOX:    out_ch_q[i] <= div9(acc_q[i]);
					ubx_pkg::CMD_BORDER: out_ch_q[i] <= acc_q[i][ubx_pkg::CH_W-1:0];
					default:             out_ch_q[i] <= '0;
				endcase
			end
		end
	end

	assign rsp.valid     = out_vld_q;
	assign rsp.out_red   = out_ch_q[0];
	assign rsp.out_green = out_ch_q[1];
	assign rsp.out_blue  = out_ch_q[2];
	assign rsp.status    = status_q;

	`UBX_ASSERT_NEXT(a_reads_drained, clk, arst_n, state_q == ubx_pkg::ST_LAST, state_q == ubx_pkg::ST_DONE && !rd_vld_q, "read data still pending when the result forms")
	`UBX_ASSERT_IMP(a_box_sum_bound, clk, arst_n, state_q == ubx_pkg::ST_DONE && cmd_q.kind == ubx_pkg::CMD_BOX, acc_q[0] <= ubx_pkg::BOX_SUM_MAX && acc_q[1] <= ubx_pkg::BOX_SUM_MAX && acc_q[2] <= ubx_pkg::BOX_SUM_MAX, "box sum exceeds nine full-scale pixels")
	`UBX_ASSERT_IMP(a_border_single, clk, arst_n, state_q == ubx_pkg::ST_DONE && cmd_q.kind == ubx_pkg::CMD_BORDER, acc_q[0] <= ubx_pkg::CH_MAX && acc_q[1] <= ubx_pkg::CH_MAX && acc_q[2] <= ubx_pkg::CH_MAX, "border pixel accumulated more than one fetch")
	`UBX_ASSERT_IMP(a_no_mem_collision, clk, arst_n, mem_we || mem_re, state_q == ubx_pkg::ST_ISSUE && !(mem_we && mem_re), "frame store port used outside an issue cycle")

endmodule

@@ dv/upscale2x_box3x3_rgb_core_tb.sv @@
// Self-checking testbench for upscale2x_box3x3_rgb_core: loads source pixels, reads upscaled
// pixels and compares every response with a built-in predictor of the frame store.
// Depends on ubx_pkg and the request/response interfaces in ubx_if.sv.
`timescale 1ns / 1ps

module upscale2x_box3x3_rgb_core_tb;

	localparam int STORE_COLS    = ubx_pkg::DEF_MAX_SRC_WIDTH;
	localparam int STORE_ROWS    = ubx_pkg::DEF_MAX_SRC_HEIGHT;
	localparam int BOX_TAPS      = 9;
	localparam int SETTLE_CYCLES = 32;
	localparam int STALL_LIMIT   = 3000;
	localparam int IDLE_PCT      = 38;

	typedef struct packed {
		logic [ubx_pkg::CH_W-1:0] red;
		logic [ubx_pkg::CH_W-1:0] green;
		logic [ubx_pkg::CH_W-1:0] blue;
		logic                     status;
	} out_pixel_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic [ubx_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ubx_pkg::CFG_DATA_W-1:0] cfg_wr_data;

	ubx_req_if req_bus();
	ubx_rsp_if rsp_bus();

	upscale2x_box3x3_rgb_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_bus),
		.rsp         (rsp_bus)
	);

	// Shadow of the frame store and the size registers.
	logic [ubx_pkg::PIX_W-1:0] src_pixels [STORE_COLS*STORE_ROWS];
	bit                        src_loaded [STORE_COLS*STORE_ROWS];
	logic [ubx_pkg::DIM_W-1:0] width_reg  = ubx_pkg::DIM_RESET;
	logic [ubx_pkg::DIM_W-1:0] height_reg = ubx_pkg::DIM_RESET;

	out_pixel_t pending_pixels[$];
	int         error_count  = 0;
	int         stall_cycles = 0;
	bit         steady_flow  = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int clamp_dim(input logic [ubx_pkg::DIM_W-1:0] v, input int maxv);
		if (v == 0)
			return 1;
		if (int'(v) > maxv)
			return maxv;
		return int'(v);
	endfunction

	function automatic int frame_cols();
		return clamp_dim(width_reg, STORE_COLS);
	endfunction

	function automatic int frame_rows();
		return clamp_dim(height_reg, STORE_ROWS);
	endfunction

	function automatic bit in_frame(input int row, input int col);
		return row < 2 * frame_rows() && col < 2 * frame_cols();
	endfunction

	// Store address of tap k of the 3x3 window. A border pixel uses the nearest source
	// pixel for all nine taps, so its mean is that pixel itself.
	function automatic int tap_address(input int row, input int col, input int k);
		int oh;
		int ow;
		int sr;
		int sc;
		oh = 2 * frame_rows();
		ow = 2 * frame_cols();
		if (row == 0 || col == 0 || row == oh - 1 || col == ow - 1) begin
			sr = row >> 1;
			sc = col >> 1;
		end else begin
			sr = (row + k / 3 - 1) >> 1;
			sc = (col + k % 3 - 1) >> 1;
		end
		return sr * STORE_COLS + sc;
	endfunction

	function automatic bit read_is_safe(input int row, input int col);
		bit ok;
		ok = 1'b1;
		if (in_frame(row, col))
			for (int k = 0; k < BOX_TAPS; k++)
				ok &= src_loaded[tap_address(row, col, k)];
		return ok;
	endfunction

	function automatic out_pixel_t upscale_pixel(input int row, input int col);
		out_pixel_t                res;
		int                        red_sum;
		int                        green_sum;
		int                        blue_sum;
		logic [ubx_pkg::PIX_W-1:0] px;
		res = '0;
		if (!in_frame(row, col)) begin
			res.status = ubx_pkg::STATUS_RANGE;
			return res;
		end
		red_sum   = 0;
		green_sum = 0;
		blue_sum  = 0;
		for (int k = 0; k < BOX_TAPS; k++) begin
			px = src_pixels[tap_address(row, col, k)];
			red_sum   += int'(px[23:16]);
			green_sum += int'(px[15:8]);
			blue_sum  += int'(px[7:0]);
		end
		res.red    = ubx_pkg::CH_W'(red_sum / BOX_TAPS);
		res.green  = ubx_pkg::CH_W'(green_sum / BOX_TAPS);
		res.blue   = ubx_pkg::CH_W'(blue_sum / BOX_TAPS);
		res.status = ubx_pkg::STATUS_OK;
		return res;
	endfunction

	function automatic logic [ubx_pkg::CH_W-1:0] rand_channel();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return ubx_pkg::CH_W'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [ubx_pkg::PIX_W-1:0] rand_pixel();
		return {rand_channel(), rand_channel(), rand_channel()};
	endfunction

	function automatic int pick_origin(input int limit);
		case ($urandom_range(3))
			0: return 0;
			1: return limit;
			default: return int'($urandom_range(limit));
		endcase
	endfunction

	// Drives one request beat and updates the shadow state once it is accepted.
	task automatic send_item(input logic act, input int row, input int col,
			input logic [ubx_pkg::PIX_W-1:0] px);
		while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid    <= 1'b1;
		req_bus.action   <= act;
		req_bus.row_pos  <= row[ubx_pkg::POS_W-1:0];
		req_bus.col_pos  <= col[ubx_pkg::POS_W-1:0];
		req_bus.in_red   <= px[23:16];
		req_bus.in_green <= px[15:8];
		req_bus.in_blue  <= px[7:0];
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		if (act == ubx_pkg::ACT_READ) begin
			pending_pixels.push_back(upscale_pixel(row, col));
		end else if (row < frame_rows() && col < frame_cols()) begin
			src_pixels[row * STORE_COLS + col] = px;
			src_loaded[row * STORE_COLS + col] = 1'b1;
		end
	endtask

	task automatic wait_drained();
		req_bus.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_pixels.size() != 0);
	endtask

	// Loads may still be in flight after the last response, so let the block settle.
	task automatic set_frame(input logic [ubx_pkg::DIM_W-1:0] w_val,
			input logic [ubx_pkg::DIM_W-1:0] h_val);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= ubx_pkg::CFG_SOURCE_WIDTH;
		cfg_wr_data <= w_val;
		@(posedge clk);
		width_reg = w_val;
		cfg_index   <= ubx_pkg::CFG_SOURCE_HEIGHT;
		cfg_wr_data <= h_val;
		@(posedge clk);
		height_reg = h_val;
		cfg_wr_en <= 1'b0;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	task automatic run_random_phase(input logic [ubx_pkg::DIM_W-1:0] w_val,
			input logic [ubx_pkg::DIM_W-1:0] h_val, input int item_goal);
		int done_items;
		int rows;
		int cols;
		int r0;
		int c0;
		int nr;
		int nc;
		int row;
		int col;
		int pick;
		set_frame(w_val, h_val);
		rows = frame_rows();
		cols = frame_cols();
		done_items = 0;
		while (done_items < item_goal) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				// Fill a small source window, then read the output pixels around it.
				nr = $urandom_range(1, rows < 4 ? rows : 4);
				nc = $urandom_range(1, cols < 4 ? cols : 4);
				r0 = pick_origin(rows - nr);
				c0 = pick_origin(cols - nc);
				for (int r = r0; r < r0 + nr; r++)
					for (int c = c0; c < c0 + nc; c++) begin
						send_item(ubx_pkg::ACT_LOAD, r, c, rand_pixel());
						done_items++;
					end
				repeat ($urandom_range(3, 10)) begin
					row = 2 * r0 - 1 + int'($urandom_range(2 * nr + 1));
					col = 2 * c0 - 1 + int'($urandom_range(2 * nc + 1));
					row = row < 0 ? 0 : (row > 2 * rows - 1 ? 2 * rows - 1 : row);
					col = col < 0 ? 0 : (col > 2 * cols - 1 ? 2 * cols - 1 : col);
					if (read_is_safe(row, col)) begin
						send_item(ubx_pkg::ACT_READ, row, col, rand_pixel());
						done_items++;
					end
				end
			end else if (pick < 82) begin
				if (pick < 70) begin
					row = $urandom_range(2 * rows - 1);
					col = $urandom_range(2 * cols - 1);
				end else begin
					row = $urandom_range(511);
					col = $urandom_range(511);
				end
				if (read_is_safe(row, col)) begin
					send_item(ubx_pkg::ACT_READ, row, col, rand_pixel());
					done_items++;
				end
			end else if (pick < 92) begin
				// Load outside the source frame; the block drops it.
				if ($urandom_range(1)) begin
					row = $urandom_range(511, rows);
					col = $urandom_range(511);
				end else begin
					row = $urandom_range(511);
					col = $urandom_range(511, cols);
				end
				send_item(ubx_pkg::ACT_LOAD, row, col, rand_pixel());
			end else begin
				send_item(ubx_pkg::ACT_LOAD, $urandom_range(rows - 1),
					$urandom_range(cols - 1), rand_pixel());
				done_items++;
			end
			if ($urandom_range(199) == 0)
				wait_drained();
		end
	endtask

	task automatic test_border_and_box();
		set_frame(9'd2, 9'd2);
		send_item(ubx_pkg::ACT_LOAD, 0, 0, 24'hFFFFFF);
		send_item(ubx_pkg::ACT_LOAD, 0, 1, 24'h000000);
		send_item(ubx_pkg::ACT_LOAD, 1, 0, 24'hAA5501);
		send_item(ubx_pkg::ACT_LOAD, 1, 1, 24'h55AAFE);
		send_item(ubx_pkg::ACT_LOAD, 2, 0, 24'h123456);
		send_item(ubx_pkg::ACT_LOAD, 511, 511, 24'hFFFFFF);
		send_item(ubx_pkg::ACT_READ, 0, 0, '0);
		send_item(ubx_pkg::ACT_READ, 3, 3, '0);
		send_item(ubx_pkg::ACT_READ, 1, 1, '0);
		send_item(ubx_pkg::ACT_READ, 1, 2, '0);
		send_item(ubx_pkg::ACT_READ, 2, 2, '0);
		send_item(ubx_pkg::ACT_READ, 2, 1, '0);
		send_item(ubx_pkg::ACT_READ, 4, 0, '0);
		send_item(ubx_pkg::ACT_READ, 0, 4, '0);
		send_item(ubx_pkg::ACT_READ, 511, 511, 24'hFFFFFF);
	endtask

	// A width of zero clamps to one, so every output pixel is on the border.
	task automatic test_single_pixel_frame();
		set_frame(9'd0, 9'd1);
		send_item(ubx_pkg::ACT_LOAD, 0, 0, 24'h0FF03C);
		send_item(ubx_pkg::ACT_LOAD, 0, 1, 24'hFFFFFF);
		send_item(ubx_pkg::ACT_READ, 0, 0, '0);
		send_item(ubx_pkg::ACT_READ, 1, 1, '0);
		send_item(ubx_pkg::ACT_READ, 1, 0, '0);
		send_item(ubx_pkg::ACT_READ, 2, 1, '0);
		send_item(ubx_pkg::ACT_READ, 1, 2, '0);
	endtask

	task automatic test_random_traffic();
		run_random_phase(9'd5, 9'd3, 200);
		run_random_phase(9'd1, 9'd9, 150);
		run_random_phase(9'd0, 9'd0, 60);
		run_random_phase(9'd511, 9'd300, 400);
		run_random_phase(9'd256, 9'd2, 200);
		run_random_phase(9'd3, 9'd256, 200);
		run_random_phase(9'd7, 9'd5, 240);
	endtask

	task automatic test_steady_stream();
		steady_flow = 1'b1;
		run_random_phase(9'd16, 9'd16, 300);
		wait_drained();
		steady_flow = 1'b0;
	endtask

	always @(posedge clk)
		rsp_bus.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		out_pixel_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected response: expected none, actual %h %h %h status %0d",
					$time, rsp_bus.out_red, rsp_bus.out_green, rsp_bus.out_blue,
					rsp_bus.status);
				error_count++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("out_red", want.red, rsp_bus.out_red);
				check_field("out_green", want.green, rsp_bus.out_green);
				check_field("out_blue", want.blue, rsp_bus.out_blue);
				check_field("status", want.status, rsp_bus.status);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
			$display("upscale2x_box3x3_rgb_core_tb: errors");
			$finish;
		end
	end

	initial begin
		arst_n           <= 1'b0;
		cfg_wr_en        <= 1'b0;
		cfg_index        <= ubx_pkg::CFG_SOURCE_WIDTH;
		cfg_wr_data      <= '0;
		req_bus.valid    <= 1'b0;
		req_bus.action   <= ubx_pkg::ACT_LOAD;
		req_bus.row_pos  <= '0;
		req_bus.col_pos  <= '0;
		req_bus.in_red   <= '0;
		req_bus.in_green <= '0;
		req_bus.in_blue  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_border_and_box();
		test_single_pixel_frame();
		test_random_traffic();
		test_steady_stream();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("upscale2x_box3x3_rgb_core_tb: clean");
		else
			$display("upscale2x_box3x3_rgb_core_tb: errors");
		$finish;
	end

endmodule
